// ----- rtl/core/vftl_pkg.sv -----
package vftl_pkg;

    // Field and arithmetic widths.
    localparam int POS_W      = 32;
    localparam int VAL_W      = 32;
    localparam int GAIN_W     = 24;
    localparam int IDX_W      = 6;
    localparam int FRAC_W     = 17;
    localparam int MUL_A_W    = 34;
    localparam int MUL_B_W    = 25;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int DIV_Q_W    = 23;
    localparam int DIV_DEN_W  = 32;
    localparam int DIV_NUM_W  = DIV_DEN_W + DIV_Q_W - 1;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Operation codes of an input word.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_X    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_Y    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_Z    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_X    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_Y    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_Z    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_Z = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN     = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_MULW,
        S_DIV,
        S_READ,
        S_LOAD,
        S_LERP,
        S_LERPW,
        S_SCALE,
        S_SCALEW,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                    op;
        logic [IDX_W-1:0]        grid_ix;
        logic [IDX_W-1:0]        grid_iy;
        logic [IDX_W-1:0]        grid_iz;
        logic signed [VAL_W-1:0] entry_bx;
        logic signed [VAL_W-1:0] entry_by;
        logic signed [VAL_W-1:0] entry_bz;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_in_word;

    typedef struct packed {
        logic signed [VAL_W-1:0] field_x;
        logic signed [VAL_W-1:0] field_y;
        logic signed [VAL_W-1:0] field_z;
        logic                    inside_region;
    } t_out_word;

    // Divider request and response.
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } t_div_rsp;

endpackage

// ----- rtl/core/vftl_ram.sv -----
module vftl_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/vftl_mul.sv -----
module vftl_mul
    import vftl_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_p
);

    logic signed [MUL_P_W-1:0] r_p;

    // Shared signed multiplier with a registered product.
    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// ----- rtl/core/vftl_div.sv -----
module vftl_div
    import vftl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIV_Q_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_Q_W-1:0]   r_low;
    logic [DIV_Q_W-1:0]   r_q;
    logic                 r_den_nz;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    // One restoring step: shift in the next numerator bit and try the divisor.
    assign trial = {r_rem, r_low[DIV_Q_W-1]};
    assign fits  = (trial >= {1'b0, r_den});

    // Sequencing of the iterations.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The quotient is known to fit, so the high numerator bits start below the divisor.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem    <= {1'b0, i_req.num[DIV_NUM_W-1:DIV_Q_W]};
            r_low    <= i_req.num[DIV_Q_W-1:0];
            r_den    <= i_req.den;
            r_den_nz <= (i_req.den != '0);
            r_q      <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? DIV_DEN_W'(trial - {1'b0, r_den}) : trial[DIV_DEN_W-1:0];
            r_low <= {r_low[DIV_Q_W-2:0], 1'b0};
            r_q   <= {r_q[DIV_Q_W-2:0], fits};
        end
    end

    // An empty span yields a zero quotient.
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_den_nz ? r_q : '0;

endmodule

// ----- rtl/core/vector_field_trilinear_lookup.sv -----
// Channel   Direction  Handshake                  Word
// in        input      i_in_valid / o_in_stall    t_in_word (table write or query)
// out       output     o_out_valid / i_out_stall  t_out_word (one per query)
// cfg       input      i_cfg_we                   i_cfg_addr, i_cfg_data
//
// A table write is stored in the cycle it is accepted. A query runs three restoring
// divisions, eight table reads, and 27 passes through the shared multiplier (one per
// axis, then seven interpolation steps and one gain step per component).
// Reset is synchronous and active low; the tables keep their contents.
// The block takes a new word while a finished result still waits in the output
// register; a query holds in its last state until that register is free.
module vector_field_trilinear_lookup
    import vftl_pkg::*;
#(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam int ENT_W = 3 * VAL_W;

    t_state r_state, n_state;

    logic signed [POS_W-1:0]  r_min_x, r_min_y, r_min_z;
    logic signed [POS_W-1:0]  r_max_x, r_max_y, r_max_z;
    logic signed [POS_W-1:0]  r_off_z;
    logic signed [GAIN_W-1:0] r_gain;

    logic signed [POS_W-1:0] r_px, r_py;
    logic signed [POS_W:0]   r_pz;
    logic [1:0]              r_axis, r_comp;
    logic [2:0]              r_step;
    logic [3:0]              r_rd;
    logic [IDX_W-1:0]        r_ix, r_iy, r_iz;
    logic [FRAC_W-1:0]       r_fx, r_fy, r_fz;
    logic [DIV_DEN_W-1:0]    r_span;
    logic [ENT_W-1:0]        r_corner [8];
    logic signed [VAL_W-1:0] r_w [8];
    logic signed [VAL_W-1:0] r_res_x, r_res_y, r_res_z;
    logic                    r_inside;
    logic                    r_out_valid;
    t_out_word               r_out;

    logic                      in_acc, out_load, in_region;
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    logic [ENT_W-1:0]          ram_rdata;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p, mul_rnd;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;
    logic signed [MUL_A_W-1:0] loc_c, loc_lo, loc_hi, loc_d, loc_span;
    logic [6:0]                loc_nm1;
    logic [6:0]                q_idx;
    logic                      q_edge;
    logic [IDX_W-1:0]          q_idx_cl;
    logic [FRAC_W-1:0]         q_frac;
    logic [FRAC_W-1:0]         lerp_f;
    logic signed [VAL_W:0]     lerp_diff;
    logic signed [VAL_W-1:0]   lerp_res, sc_res;
    logic [2:0]                ins_pos;
    logic [2:0]                crn;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // Table store: all three components of a node in one entry.
    assign ram_we    = in_acc && (i_in_word.op == OP_WRITE)
                       && ({1'b0, i_in_word.grid_ix} < 7'(GRID_X))
                       && ({1'b0, i_in_word.grid_iy} < 7'(GRID_Y))
                       && ({1'b0, i_in_word.grid_iz} < 7'(GRID_Z));
    assign ram_waddr = AW'((int'(i_in_word.grid_ix) * GRID_Y + int'(i_in_word.grid_iy))
                           * GRID_Z + int'(i_in_word.grid_iz));
    assign crn       = r_rd[2:0];
    assign ram_raddr = AW'((int'(r_ix) + int'(crn[2])) * GRID_Y * GRID_Z
                           + (int'(r_iy) + int'(crn[1])) * GRID_Z
                           + int'(r_iz) + int'(crn[0]));

    vftl_ram #(.W(ENT_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({i_in_word.entry_bz, i_in_word.entry_by, i_in_word.entry_bx}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    vftl_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    vftl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Region check on the offset point.
    assign in_region = (r_px >= r_min_x) && (r_px <= r_max_x)
                    && (r_py >= r_min_y) && (r_py <= r_max_y)
                    && (r_pz >= (POS_W+1)'(r_min_z)) && (r_pz <= (POS_W+1)'(r_max_z));

    // Operands of the current axis for the cell search.
    always_comb begin
        case (r_axis)
            2'd0: begin
                loc_c = MUL_A_W'(r_px); loc_lo = MUL_A_W'(r_min_x);
                loc_hi = MUL_A_W'(r_max_x); loc_nm1 = 7'(GRID_X - 1);
            end
            2'd1: begin
                loc_c = MUL_A_W'(r_py); loc_lo = MUL_A_W'(r_min_y);
                loc_hi = MUL_A_W'(r_max_y); loc_nm1 = 7'(GRID_Y - 1);
            end
            default: begin
                loc_c = MUL_A_W'(r_pz); loc_lo = MUL_A_W'(r_min_z);
                loc_hi = MUL_A_W'(r_max_z); loc_nm1 = 7'(GRID_Z - 1);
            end
        endcase
        loc_d    = loc_c - loc_lo;
        loc_span = loc_hi - loc_lo;
    end

    // Quotient split into cell and fraction; the upper edge clamps to the last cell.
    assign q_idx    = div_rsp.quot[DIV_Q_W-1:16];
    assign q_edge   = (q_idx >= loc_nm1);
    assign q_idx_cl = q_edge ? IDX_W'(loc_nm1 - 7'd1) : q_idx[IDX_W-1:0];
    assign q_frac   = q_edge ? FRAC_W'(65536) : {1'b0, div_rsp.quot[15:0]};

    // One interpolation step works on the two front values of the queue.
    assign lerp_f    = (r_step < 3'd4) ? r_fz : ((r_step < 3'd6) ? r_fy : r_fx);
    assign lerp_diff = (VAL_W+1)'(r_w[1]) - (VAL_W+1)'(r_w[0]);
    assign mul_rnd   = (mul_p + MUL_P_W'(32768)) >>> 16;
    assign lerp_res  = r_w[0] + mul_rnd[VAL_W-1:0];
    assign ins_pos   = 3'd6 - r_step;

    // Gain product rounded and saturated.
    always_comb begin
        if (mul_rnd > MUL_P_W'(64'sh7FFFFFFF)) begin
            sc_res = 32'sh7FFFFFFF;
        end else if (mul_rnd < -MUL_P_W'(64'sh80000000)) begin
            sc_res = 32'sh80000000;
        end else begin
            sc_res = mul_rnd[VAL_W-1:0];
        end
    end

    // Sequencer: next state and shared unit operands.
    always_comb begin
        n_state       = r_state;
        mul_a         = '0;
        mul_b         = '0;
        div_req.start = 1'b0;
        div_req.num   = {mul_p[DIV_NUM_W-17:0], 16'h0000};
        div_req.den   = r_span;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_word.op == OP_QUERY) n_state = S_CHECK;
            end
            S_CHECK: n_state = in_region ? S_MUL : S_OUT;
            S_MUL: begin
                mul_a   = $signed({2'b00, loc_d[DIV_DEN_W-1:0]});
                mul_b   = MUL_B_W'(loc_nm1);
                n_state = S_MULW;
            end
            S_MULW: begin
                div_req.start = 1'b1;
                n_state       = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) n_state = (r_axis == 2'd2) ? S_READ : S_MUL;
            end
            S_READ: begin
                if (r_rd == 4'd8) n_state = S_LOAD;
            end
            S_LOAD: n_state = S_LERP;
            S_LERP: begin
                mul_a   = MUL_A_W'(lerp_diff);
                mul_b   = $signed({{(MUL_B_W-FRAC_W){1'b0}}, lerp_f});
                n_state = S_LERPW;
            end
            S_LERPW: n_state = (r_step == 3'd6) ? S_SCALE : S_LERP;
            S_SCALE: begin
                mul_a   = MUL_A_W'(r_w[0]);
                mul_b   = MUL_B_W'(r_gain);
                n_state = S_SCALEW;
            end
            S_SCALEW: n_state = (r_comp == 2'd2) ? S_OUT : S_LOAD;
            S_OUT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_min_x     <= '0;
            r_min_y     <= '0;
            r_min_z     <= '0;
            r_max_x     <= 32'sd65536;
            r_max_y     <= 32'sd65536;
            r_max_z     <= 32'sd65536;
            r_off_z     <= '0;
            r_gain      <= 24'sd65536;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_MIN_X:    r_min_x <= i_cfg_data;
                    REG_MIN_Y:    r_min_y <= i_cfg_data;
                    REG_MIN_Z:    r_min_z <= i_cfg_data;
                    REG_MAX_X:    r_max_x <= i_cfg_data;
                    REG_MAX_Y:    r_max_y <= i_cfg_data;
                    REG_MAX_Z:    r_max_z <= i_cfg_data;
                    REG_OFFSET_Z: r_off_z <= i_cfg_data;
                    REG_GAIN:     r_gain  <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers, stepped by the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_px <= i_in_word.pos_x;
                r_py <= i_in_word.pos_y;
                r_pz <= (POS_W+1)'(i_in_word.pos_z) + (POS_W+1)'(r_off_z);
            end
            S_CHECK: begin
                r_axis   <= 2'd0;
                r_inside <= 1'b0;
                r_res_x  <= '0;
                r_res_y  <= '0;
                r_res_z  <= '0;
            end
            S_MUL: r_span <= loc_span[DIV_DEN_W-1:0];
            S_DIV: begin
                if (div_rsp.done) begin
                    case (r_axis)
                        2'd0: begin r_ix <= q_idx_cl; r_fx <= q_frac; end
                        2'd1: begin r_iy <= q_idx_cl; r_fy <= q_frac; end
                        default: begin r_iz <= q_idx_cl; r_fz <= q_frac; end
                    endcase
                    r_axis <= r_axis + 2'd1;
                    r_rd   <= 4'd0;
                end
            end
            S_READ: begin
                r_rd   <= r_rd + 4'd1;
                r_comp <= 2'd0;
                if (r_rd != 4'd0) begin
                    for (int k = 0; k < 7; k++) r_corner[k] <= r_corner[k+1];
                    r_corner[7] <= ram_rdata;
                end
            end
            S_LOAD: begin
                r_step <= 3'd0;
                for (int k = 0; k < 8; k++) begin
                    case (r_comp)
                        2'd0:    r_w[k] <= r_corner[k][VAL_W-1:0];
                        2'd1:    r_w[k] <= r_corner[k][2*VAL_W-1:VAL_W];
                        default: r_w[k] <= r_corner[k][3*VAL_W-1:2*VAL_W];
                    endcase
                end
            end
            S_LERPW: begin
                // Drop the two front values and queue the result behind the rest.
                r_step <= r_step + 3'd1;
                for (int k = 0; k < 8; k++) begin
                    if (3'(k) == ins_pos) begin
                        r_w[k] <= lerp_res;
                    end else if (k < 6) begin
                        r_w[k] <= r_w[k+2];
                    end
                end
            end
            S_SCALEW: begin
                r_comp <= r_comp + 2'd1;
                case (r_comp)
                    2'd0: r_res_x <= sc_res;
                    2'd1: r_res_y <= sc_res;
                    default: begin
                        r_res_z  <= sc_res;
                        r_inside <= 1'b1;
                    end
                endcase
            end
            default: ;
        endcase
        if (out_load) begin
            r_out.field_x       <= r_res_x;
            r_out.field_y       <= r_res_y;
            r_out.field_z       <= r_res_z;
            r_out.inside_region <= r_inside;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // A result appears only after the sequencer has finished a query.
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result word raised outside the output step");

    // A table write never produces a result.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.op == OP_WRITE) |=> !$rose(r_out_valid))
        else $error("table write produced a result word");

    // A point outside the region reports a zero field.
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.inside_region) |->
        (r_out.field_x == '0 && r_out.field_y == '0 && r_out.field_z == '0))
        else $error("outside point with nonzero field");

    // The divider finishes only while the sequencer waits for it.
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == S_DIV)
        else $error("divider finished outside its wait step");

endmodule
